/* src/ps2_bus_frame_monitor_defines.svh */
// Assertion macros for the PS/2 bus frame monitor.
// Each macro assumes clk and rst are visible in the module that uses it.
`ifndef PS2_BUS_FRAME_MONITOR_DEFINES_SVH
`define PS2_BUS_FRAME_MONITOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define PS2BFM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ps2_bus_frame_monitor: assertion failed");

// Next-cycle implication
`define PS2BFM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ps2_bus_frame_monitor: assertion failed");

`else

`define PS2BFM_ASSERT_IMP(lbl, ante, cons)
`define PS2BFM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* src/ps2bfm_pkg.sv */
`default_nettype none

package ps2bfm_pkg;

  // Frame tracking phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_H_DATA,
    PH_H_STOP,
    PH_H_ACKFALL,
    PH_H_ACKRISE,
    PH_D_DATA,
    PH_D_NEXT
  } phase_t;

  // Register indexes on the config port
  localparam logic REG_HOST_EDGE   = 1'b0;
  localparam logic REG_DEVICE_EDGE = 1'b1;

  // Result kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  // Edge select codes
  localparam logic EDGE_RISE = 1'b0;
  localparam logic EDGE_FALL = 1'b1;

  // Frame bit counts
  localparam logic [3:0] HOST_DATA_END  = 4'd10;
  localparam logic [3:0] FRAME_BITS_END = 4'd11;
  localparam logic [3:0] BIT_INDEX_MAX  = 4'd15;
  localparam int         FRAME_BITS_W   = 12;

  localparam int QUEUE_DEPTH = 4;

  // One classified sample handed from front to back
  typedef struct packed {
    logic data_level;
    logic c_rise;
    logic c_fall;
    logic d_rise;
    logic d_fall;
  } evt_t;

  // One result item
  typedef struct packed {
    logic       event_kind;
    logic [7:0] frame_byte;
    logic       host_to_device;
    logic       parity_good;
    logic       stop_level;
    logic       ack_level;
  } result_t;

endpackage

`default_nettype wire

/* src/ps2_bus_frame_monitor.sv */
// The frame tracker takes an accepted item from the queue when its result slot
// is free and registers its result, which is then valid on the master side.
// Throughput: one item per cycle unless the queue is full; a four-entry queue
// between edge detection and the frame tracker absorbs short master-side stalls.
// Reset: synchronous, active high; clears edge history, frame state, queue and
// output, and sets the sample-edge registers to rising (host), falling (device).
`default_nettype none

module ps2_bus_frame_monitor #(
  parameter int QueueDepth = ps2bfm_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst,
  // config
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire         cfg_data,
  // sample input
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [0] clk_level, [1] data_level, [7:2] zero
  // result output
  output logic        m_tvalid,
  input  wire         m_tready,
  // [7:0] frame_byte, [8] host_to_device, [9] parity_good, [10] stop_level,
  // [11] ack_level, [15:12] zero
  output logic [15:0] m_tdata,
  output logic        m_tuser    // [0] event_kind
);
  import ps2bfm_pkg::*;

  logic    push;
  evt_t    push_evt;
  logic    q_full;
  logic    q_valid;
  evt_t    q_head;
  logic    q_pop;
  result_t res;

  ps2bfm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .clk_level  (s_tdata[0]),
    .data_level (s_tdata[1]),
    .push       (push),
    .push_evt   (push_evt),
    .q_full     (q_full)
  );

  ps2bfm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_evt (push_evt),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  ps2bfm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (res)
  );

  // Pack result fields
  assign m_tuser = res.event_kind;
  assign m_tdata = {4'b0000, res.ack_level, res.stop_level, res.parity_good,
                    res.host_to_device, res.frame_byte};

endmodule

`default_nettype wire

/* src/ps2bfm_front.sv */
`default_nettype none

module ps2bfm_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 clk_level,
  input  wire                 data_level,
  output logic                push,
  output ps2bfm_pkg::evt_t    push_evt,
  input  wire                 q_full
);
  import ps2bfm_pkg::*;

  logic primed;
  logic prev_clk;
  logic prev_data;
  logic accept;

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;

  // Edge classification against the previous sample
  assign push                = accept & primed;
  assign push_evt.data_level = data_level;
  assign push_evt.c_rise     = ~prev_clk & clk_level;
  assign push_evt.c_fall     = prev_clk & ~clk_level;
  assign push_evt.d_rise     = ~prev_data & data_level;
  assign push_evt.d_fall     = prev_data & ~data_level;

  // Previous levels; the first item only primes them
  always_ff @(posedge clk) begin
    if (rst) begin
      primed    <= 1'b0;
      prev_clk  <= 1'b0;
      prev_data <= 1'b0;
    end else if (accept) begin
      primed    <= 1'b1;
      prev_clk  <= clk_level;
      prev_data <= data_level;
    end
  end

endmodule

`default_nettype wire

/* src/ps2bfm_queue.sv */
`default_nettype none
`include "ps2_bus_frame_monitor_defines.svh"

module ps2bfm_queue #(
  parameter int Depth = ps2bfm_pkg::QUEUE_DEPTH
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  ps2bfm_pkg::evt_t  push_evt,
  output logic              full,
  output logic              valid,
  output ps2bfm_pkg::evt_t  head,
  input  wire               pop
);
  import ps2bfm_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  evt_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntFull);
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_evt;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `PS2BFM_ASSERT_IMP(a_no_push_full, push, !full)
  `PS2BFM_ASSERT_IMP(a_no_pop_empty, pop, valid)
  `PS2BFM_ASSERT_IMP(a_count_range, 1'b1, count <= CntFull)

endmodule

`default_nettype wire

/* src/ps2bfm_back.sv */
`default_nettype none
`include "ps2_bus_frame_monitor_defines.svh"

module ps2bfm_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire                  cfg_index,
  input  wire                  cfg_data,
  input  wire                  q_valid,
  input  ps2bfm_pkg::evt_t     q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire                  out_ready,
  output ps2bfm_pkg::result_t  out_result
);
  import ps2bfm_pkg::*;

  logic host_sample_edge;
  logic device_sample_edge;

  phase_t                  phase, phase_next;
  logic [3:0]              bit_index, bit_index_next;
  logic [FRAME_BITS_W-1:0] frame_bits, frame_bits_next;
  logic                    host_dir, host_dir_next;
  logic                    host_start_armed, host_start_armed_next;

  logic    store, start, emit;
  logic    emit_kind, emit_ack;
  logic    edge_hit;
  logic    d;
  result_t res;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      host_sample_edge   <= EDGE_RISE;
      device_sample_edge <= EDGE_FALL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOST_EDGE:   host_sample_edge   <= cfg_data;
        REG_DEVICE_EDGE: device_sample_edge <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Take a sample whenever the result slot can accept
  assign q_pop = q_valid & (~out_valid | out_ready);
  assign d     = q_head.data_level;

  // Frame state machine
  always_comb begin
    phase_next            = phase;
    host_dir_next         = host_dir;
    host_start_armed_next = host_start_armed;
    store                 = 1'b0;
    start                 = 1'b0;
    emit                  = 1'b0;
    emit_kind             = KIND_FRAME;
    emit_ack              = 1'b0;
    edge_hit              = 1'b0;

    case (phase)
      PH_IDLE: begin
        if (host_start_armed) begin
          if (q_head.c_rise && !d) begin
            host_start_armed_next = 1'b0;
            start                 = 1'b1;
            host_dir_next         = 1'b1;
            phase_next            = PH_H_DATA;
          end
        end else if (q_head.c_fall && !q_head.d_rise) begin
          start         = 1'b1;
          host_dir_next = q_head.d_fall | d;
          phase_next    = (q_head.d_fall | d) ? PH_H_DATA : PH_D_DATA;
        end
      end
      PH_H_DATA: begin
        edge_hit = (host_sample_edge == EDGE_FALL) ? q_head.c_fall : q_head.c_rise;
        if (edge_hit) begin
          store = 1'b1;
          if (bit_index_next == HOST_DATA_END) begin
            phase_next = PH_H_STOP;
          end
        end
      end
      PH_H_STOP: begin
        if (q_head.c_rise) begin
          store      = 1'b1;
          emit       = 1'b1;
          phase_next = PH_H_ACKFALL;
        end
      end
      PH_H_ACKFALL: begin
        if (q_head.c_fall) begin
          store      = 1'b1;
          phase_next = PH_H_ACKRISE;
        end
      end
      PH_H_ACKRISE: begin
        if (q_head.c_rise) begin
          emit          = 1'b1;
          emit_kind     = KIND_ACK;
          emit_ack      = frame_bits[FRAME_BITS_W-1];
          host_dir_next = 1'b0;
          phase_next    = PH_IDLE;
        end
      end
      PH_D_DATA: begin
        edge_hit = (device_sample_edge == EDGE_FALL) ? q_head.c_fall : q_head.c_rise;
        if (edge_hit) begin
          store = 1'b1;
          if (bit_index_next == FRAME_BITS_END) begin
            emit       = 1'b1;
            phase_next = PH_D_NEXT;
          end
        end
      end
      PH_D_NEXT: begin
        if (q_head.d_fall) begin
          host_start_armed_next = 1'b1;
          host_dir_next         = 1'b1;
          phase_next            = PH_IDLE;
        end else if (q_head.c_rise) begin
          host_start_armed_next = 1'b0;
          host_dir_next         = 1'b0;
          phase_next            = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Bit store: a frame start stores the start bit at position zero
  always_comb begin
    frame_bits_next = frame_bits;
    bit_index_next  = bit_index;
    if (start) begin
      frame_bits_next    = '0;
      frame_bits_next[0] = d;
      bit_index_next     = 4'd1;
    end else if (store) begin
      for (int i = 0; i < FRAME_BITS_W; i++) begin
        if (bit_index == 4'(i)) begin
          frame_bits_next[i] = d;
        end
      end
      if (bit_index != BIT_INDEX_MAX) begin
        bit_index_next = bit_index + 4'd1;
      end
    end
  end

  // Result fields; byte, parity and stop level come from the updated frame bits
  always_comb begin
    res.event_kind     = emit_kind;
    res.frame_byte     = frame_bits_next[8:1];
    res.host_to_device = host_dir;
    res.parity_good    = ^frame_bits_next[9:1];
    res.stop_level     = frame_bits_next[10];
    res.ack_level      = emit_ack;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      bit_index        <= '0;
      frame_bits       <= '0;
      host_dir         <= 1'b0;
      host_start_armed <= 1'b0;
    end else if (q_pop) begin
      phase            <= phase_next;
      bit_index        <= bit_index_next;
      frame_bits       <= frame_bits_next;
      host_dir         <= host_dir_next;
      host_start_armed <= host_start_armed_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_result <= res;
    end
  end

  `PS2BFM_ASSERT_IMP(a_emit_phase, q_pop && emit,
    phase == PH_H_STOP || phase == PH_H_ACKRISE || phase == PH_D_DATA)
  `PS2BFM_ASSERT_IMP(a_bit_index_range, 1'b1, bit_index <= 4'd12)
  `PS2BFM_ASSERT_IMP(a_armed_idle, host_start_armed, phase == PH_IDLE)
  `PS2BFM_ASSERT_NEXT(a_ack_is_host, q_pop && emit && emit_kind == KIND_ACK,
    out_valid && out_result.host_to_device)

endmodule

`default_nettype wire
